[design/vgs_pkg.sv]
// Shared constants, codes and sine lookup for the panning gain solver.
`default_nettype none

package vgs_pkg;

   // default table sizes
   localparam int VGS_MAX_TUPLES   = 64;
   localparam int VGS_MAX_SPEAKERS = 64;

   // input actions
   localparam logic [1:0] ACT_COEF    = 2'd0;
   localparam logic [1:0] ACT_SPK     = 2'd1;
   localparam logic [1:0] ACT_COMPUTE = 2'd2;

   // register indexes (word address bit 2)
   localparam logic REG_DIMENSION   = 1'b0;
   localparam logic REG_TUPLE_COUNT = 1'b1;

   localparam logic [1:0] DIM_TRIPLET = 2'd3;

   // quarter-wave sine, Q1.14, one entry per degree
   localparam logic [14:0] SINE_Q14 [91] = '{
          0,   286,   572,   857,  1143,  1428,  1713,  1997,  2280,  2563,
       2845,  3126,  3406,  3686,  3964,  4240,  4516,  4790,  5063,  5334,
       5604,  5872,  6138,  6402,  6664,  6924,  7182,  7438,  7692,  7943,
       8192,  8438,  8682,  8923,  9162,  9397,  9630,  9860, 10087, 10311,
      10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
      12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
      14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
      15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
      16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
      16384
   };

   // sine of a whole degree in 0..359, signed Q1.14
   function automatic logic signed [15:0] sin_deg(input logic [8:0] d);
      logic [8:0] t;
      logic [15:0] m;
      begin
         if (d <= 9'd90) begin
            t = d;
         end else if (d <= 9'd180) begin
            t = 9'd180 - d;
         end else if (d <= 9'd270) begin
            t = d - 9'd180;
         end else begin
            t = 9'd360 - d;
         end
         m = {1'b0, SINE_Q14[t[6:0]]};
         sin_deg = (d > 9'd180) ? $signed(16'd0 - m) : $signed(m);
      end
   endfunction

endpackage

`default_nettype wire

[design/vbap_gain_solver.sv]
// Top level of the panning gain solver: tuple store, search sequencer, normalizer.
`default_nettype none
// Usage
// req channel (valid/ready): one beat per action. Coefficient and speaker id
// writes land in the tuple store in the accepting cycle and give no result.
// A compute beat yields one rsp beat with normalized Q1.14 gains and ids.
// A compute steps through direction lookup, the search (it reads one matrix
// coefficient per cycle from the coefficient memory), a pipeline drain, then
// rounding, squares, a 30-step square root, three 15-step divisions and
// speaker id reads; search and drain are skipped when tuple_count is 0.
// rsp_valid rises once the speaker ids are read. req_ready is high only
// while the sequencer idles; one compute is in flight at a time.
// The result sits in an output register; a new beat is accepted while it
// waits, and a finished compute holds until rsp_ready frees the register.
// Reset (synchronous) sets dimension 2 and tuple_count 0 and clears control
// state; the stores are not cleared and must be written before use.
// csr_* is an APB-style port: dimension at 0x0, tuple_count at 0x4.
module vbap_gain_solver
   import vgs_pkg::*;
#(
   parameter int MAX_TUPLES   = VGS_MAX_TUPLES,
   parameter int MAX_SPEAKERS = VGS_MAX_SPEAKERS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_action,
   input  wire logic [5:0]         req_tuple_index,
   input  wire logic [3:0]         req_element_index,
   input  wire logic signed [15:0] req_coefficient,
   input  wire logic [5:0]         req_speaker_number,
   input  wire logic [8:0]         req_azimuth,
   input  wire logic signed [7:0]  req_elevation,
   // response channel
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [15:0]      rsp_gain_first,
   output logic signed [15:0]      rsp_gain_second,
   output logic signed [15:0]      rsp_gain_third,
   output logic [5:0]              rsp_speaker_first,
   output logic [5:0]              rsp_speaker_second,
   output logic [5:0]              rsp_speaker_third,
   output logic                    rsp_third_used,
   // register port
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [2:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   localparam int CAW = $clog2(MAX_TUPLES * 9);
   localparam int SAW = $clog2(MAX_TUPLES * 3);
   localparam int TCW = $clog2(MAX_TUPLES + 1);
   localparam int WAW = (CAW > 10) ? CAW : 10;
   localparam int SWW = (SAW > 8) ? SAW : 8;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b00000000001,
      ST_DIR    = 11'b00000000010,
      ST_VEC    = 11'b00000000100,
      ST_SEARCH = 11'b00000001000,
      ST_DRAIN  = 11'b00000010000,
      ST_ROUND  = 11'b00000100000,
      ST_SQR    = 11'b00001000000,
      ST_ROOT   = 11'b00010000000,
      ST_DLOAD  = 11'b00100000000,
      ST_DIV    = 11'b01000000000,
      ST_SPK    = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   // ---------------- configuration registers
   logic [1:0] dimension_ff;
   logic [6:0] tuple_count_ff;
   logic       csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         dimension_ff   <= 2'd2;
         tuple_count_ff <= 7'd0;
      end else if (csr_write) begin
         if (csr_paddr[2] == REG_DIMENSION) begin
            dimension_ff <= csr_pwdata[1:0];
         end else begin
            tuple_count_ff <= csr_pwdata[6:0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == REG_TUPLE_COUNT) begin
         csr_prdata = {25'd0, tuple_count_ff};
      end else begin
         csr_prdata = {30'd0, dimension_ff};
      end
   end

   logic       tri_mode;
   logic [1:0] dim_last;
   assign tri_mode = (dimension_ff == DIM_TRIPLET);
   assign dim_last = tri_mode ? 2'd2 : 2'd1;

   // ---------------- request accept and store writes
   logic accept, tup_ok, coef_we, spk_we;
   logic [WAW-1:0] coef_wa_full;
   logic [SWW-1:0] spk_wa_full;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign tup_ok    = ({3'd0, req_tuple_index} < 9'(MAX_TUPLES));
   assign coef_we   = accept && (req_action == ACT_COEF) && tup_ok
                      && (req_element_index < 4'd9);
   assign spk_we    = accept && (req_action == ACT_SPK) && tup_ok
                      && (req_element_index < 4'd3)
                      && ({3'd0, req_speaker_number} < 9'(MAX_SPEAKERS));

   assign coef_wa_full = WAW'({req_tuple_index, 3'd0}) + WAW'(req_tuple_index)
                         + WAW'(req_element_index);
   assign spk_wa_full  = SWW'({req_tuple_index, 1'b0}) + SWW'(req_tuple_index)
                         + SWW'(req_element_index);

   // ---------------- tuple stores
   logic signed [15:0] coef_mem [MAX_TUPLES * 9];
   logic [5:0]         spk_mem  [MAX_TUPLES * 3];
   logic signed [15:0] coef_rd_ff;
   logic [5:0]         spk_rd_ff;
   logic [CAW-1:0]     coef_ra;
   logic [SAW-1:0]     spk_ra;

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_wa_full[CAW-1:0]] <= req_coefficient;
      end
      coef_rd_ff <= coef_mem[coef_ra];
   end

   always_ff @(posedge clock) begin
      if (spk_we) begin
         spk_mem[spk_wa_full[SAW-1:0]] <= req_speaker_number;
      end
      spk_rd_ff <= spk_mem[spk_ra];
   end

   // ---------------- direction lookup
   logic [8:0]         az_ff;
   logic signed [7:0]  el_ff;
   logic signed [15:0] ca_ff, sa_ff, ce_ff, se_ff;
   logic [8:0]         az_r;
   logic [9:0]         az_c;
   logic [8:0]         az_cr;
   logic signed [7:0]  el_c;
   logic [6:0]         el_abs;
   logic [15:0]        se_mag;

   always_comb begin
      az_r  = (az_ff >= 9'd360) ? az_ff - 9'd360 : az_ff;
      az_c  = {1'b0, az_r} + 10'd90;
      az_cr = (az_c >= 10'd360) ? 9'(az_c - 10'd360) : az_c[8:0];
      if (el_ff > 8'sd90) begin
         el_c = 8'sd90;
      end else if (el_ff < -8'sd90) begin
         el_c = -8'sd90;
      end else begin
         el_c = el_ff;
      end
      el_abs = el_c[7] ? 7'(8'd0 - el_c) : el_c[6:0];
      se_mag = {1'b0, SINE_Q14[el_abs]};
   end

   // direction vector, Q1.28
   logic signed [29:0] dir_ff [3];
   logic signed [31:0] dir_x, dir_y;
   assign dir_x = ca_ff * ce_ff;
   assign dir_y = sa_ff * ce_ff;

   // ---------------- search sequencer
   logic [TCW-1:0] n_ff, i_ff;
   logic [8:0]     n_full;
   logic [CAW-1:0] base_ff;
   logic [3:0]     elem_ff;
   logic [1:0]     j_ff, k_ff;

   assign n_full  = ({2'd0, tuple_count_ff} > 9'(MAX_TUPLES)) ? 9'(MAX_TUPLES)
                    : {2'd0, tuple_count_ff};
   assign coef_ra = base_ff + CAW'(elem_ff);

   // pipeline: read -> multiply -> accumulate -> compare
   logic           p1_valid_ff, p2_valid_ff, p3_valid_ff;
   logic [1:0]     p1_k_ff, p1_j_ff, p2_j_ff;
   logic           p1_kfirst_ff, p1_klast_ff, p1_jlast_ff;
   logic           p2_kfirst_ff, p2_klast_ff, p2_jlast_ff;
   logic [TCW-1:0] p1_t_ff, p2_t_ff, p3_t_ff;
   logic signed [45:0] prod_ff;
   logic signed [47:0] acc_ff, acc_sum, mn_ff, best_min_ff;
   logic signed [47:0] gt_ff [3];
   logic signed [47:0] best_raw_ff [3];
   logic [TCW-1:0] best_t_ff;
   logic           chosen_ff;

   assign acc_sum = (p2_kfirst_ff ? 48'sd0 : acc_ff)
                    + $signed({{2{prod_ff[45]}}, prod_ff});

   // ---------------- normalizer
   logic [27:0] gmag_ff [3];
   logic        gneg_ff [3];
   logic [59:0] sum_ff, res_ff, bit_ff, root_trial;
   logic [55:0] sq;
   logic [1:0]  cnt_ff, slot_ff;
   logic [3:0]  bcnt_ff;
   logic [44:0] rem_ff, ds_ff;
   logic [14:0] q_ff, q_next;
   logic [29:0] p_root;
   logic signed [15:0] gain_ff [3];
   logic [5:0]  id_ff [3];

   assign sq         = gmag_ff[cnt_ff] * gmag_ff[cnt_ff];
   assign root_trial = res_ff + bit_ff;
   assign p_root     = res_ff[29:0];
   // slot address stays on the third id while the result waits
   assign spk_ra     = SAW'({best_t_ff, 1'b0}) + SAW'(best_t_ff)
                       + SAW'((cnt_ff == 2'd3) ? 2'd2 : cnt_ff);

   always_comb begin
      q_next = q_ff;
      if (rem_ff >= ds_ff) begin
         q_next[bcnt_ff] = 1'b1;
      end
   end

   // ---------------- output register
   logic               rsp_valid_ff;
   logic signed [15:0] out_gain_ff [3];
   logic [5:0]         out_id_ff [3];
   logic               out_third_ff;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_gain_first     = out_gain_ff[0];
   assign rsp_gain_second    = out_gain_ff[1];
   assign rsp_gain_third     = out_gain_ff[2];
   assign rsp_speaker_first  = out_id_ff[0];
   assign rsp_speaker_second = out_id_ff[1];
   assign rsp_speaker_third  = out_id_ff[2];
   assign rsp_third_used     = out_third_ff;

   // ---------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_action == ACT_COMPUTE)) begin
               state_in = ST_DIR;
            end
         end
         ST_DIR:  state_in = ST_VEC;
         ST_VEC:  state_in = (n_full == 9'd0) ? ST_ROUND : ST_SEARCH;
         ST_SEARCH: begin
            if ((k_ff == dim_last) && (j_ff == dim_last) && (i_ff == n_ff - TCW'(1))) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!p1_valid_ff && !p2_valid_ff && !p3_valid_ff) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: state_in = ST_SQR;
         ST_SQR:   state_in = (cnt_ff == 2'd2) ? ST_ROOT : ST_SQR;
         ST_ROOT:  state_in = (bit_ff == 60'd1) ? ST_DLOAD : ST_ROOT;
         ST_DLOAD: state_in = ST_DIV;
         ST_DIV: begin
            if (bcnt_ff == 4'd0) begin
               state_in = (slot_ff == 2'd2) ? ST_SPK : ST_DLOAD;
            end
         end
         ST_SPK: begin
            if ((cnt_ff == 2'd3) && !rsp_valid_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         p1_valid_ff <= (state_ff == ST_SEARCH);
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff && p2_klast_ff && p2_jlast_ff;
         if ((state_ff == ST_SPK) && (cnt_ff == 2'd3) && !rsp_valid_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------- datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         az_ff <= req_azimuth;
         el_ff <= req_elevation;
      end

      // table lookups
      if (state_ff == ST_DIR) begin
         ca_ff <= sin_deg(az_cr);
         sa_ff <= sin_deg(az_r);
         ce_ff <= {1'b0, SINE_Q14[7'd90 - el_abs]};
         se_ff <= el_c[7] ? $signed(16'd0 - se_mag) : $signed(se_mag);
      end

      // vector products and search setup
      if (state_ff == ST_VEC) begin
         dir_ff[0]      <= dir_x[29:0];
         dir_ff[1]      <= dir_y[29:0];
         dir_ff[2]      <= {se_ff[15:0], 14'd0};
         n_ff           <= n_full[TCW-1:0];
         i_ff           <= '0;
         base_ff        <= '0;
         elem_ff        <= 4'd0;
         j_ff           <= 2'd0;
         k_ff           <= 2'd0;
         chosen_ff      <= 1'b0;
         best_raw_ff[0] <= '0;
         best_raw_ff[1] <= '0;
         best_raw_ff[2] <= '0;
      end

      // coefficient read issue
      if (state_ff == ST_SEARCH) begin
         p1_k_ff      <= k_ff;
         p1_j_ff      <= j_ff;
         p1_kfirst_ff <= (k_ff == 2'd0);
         p1_klast_ff  <= (k_ff == dim_last);
         p1_jlast_ff  <= (j_ff == dim_last);
         p1_t_ff      <= i_ff;
         if (k_ff == dim_last) begin
            k_ff <= 2'd0;
            if (j_ff == dim_last) begin
               j_ff    <= 2'd0;
               elem_ff <= 4'd0;
               base_ff <= base_ff + CAW'(9);
               i_ff    <= i_ff + TCW'(1);
            end else begin
               j_ff    <= j_ff + 2'd1;
               elem_ff <= elem_ff + 4'd1;
            end
         end else begin
            k_ff    <= k_ff + 2'd1;
            elem_ff <= elem_ff + 4'd1;
         end
      end

      // multiply
      prod_ff      <= dir_ff[p1_k_ff] * coef_rd_ff;
      p2_j_ff      <= p1_j_ff;
      p2_kfirst_ff <= p1_kfirst_ff;
      p2_klast_ff  <= p1_klast_ff;
      p2_jlast_ff  <= p1_jlast_ff;
      p2_t_ff      <= p1_t_ff;

      // accumulate, row gain and row minimum
      if (p2_valid_ff) begin
         acc_ff <= acc_sum;
         if (p2_klast_ff) begin
            gt_ff[p2_j_ff] <= acc_sum;
            if ((p2_j_ff == 2'd0) || (acc_sum < mn_ff)) begin
               mn_ff <= acc_sum;
            end
         end
      end
      p3_t_ff <= p2_t_ff;

      // keep the first tuple with the largest minimum
      if (p3_valid_ff && (!chosen_ff || (mn_ff > best_min_ff))) begin
         chosen_ff      <= 1'b1;
         best_min_ff    <= mn_ff;
         best_raw_ff[0] <= gt_ff[0];
         best_raw_ff[1] <= gt_ff[1];
         best_raw_ff[2] <= tri_mode ? gt_ff[2] : 48'sd0;
         best_t_ff      <= p3_t_ff;
      end

      // round gains to Q20 as sign and magnitude
      if (state_ff == ST_ROUND) begin
         for (int m = 0; m < 3; m++) begin
            logic [47:0] mag;
            logic [47:0] rnd;
            mag = best_raw_ff[m][47] ? 48'd0 - best_raw_ff[m] : best_raw_ff[m];
            rnd = mag + 48'h80000;
            gmag_ff[m] <= rnd[47:20];
            gneg_ff[m] <= best_raw_ff[m][47];
         end
         sum_ff <= '0;
         cnt_ff <= 2'd0;
      end

      // sum of squares
      if (state_ff == ST_SQR) begin
         sum_ff <= sum_ff + {4'd0, sq};
         cnt_ff <= cnt_ff + 2'd1;
         if (cnt_ff == 2'd2) begin
            res_ff <= '0;
            bit_ff <= 60'd1 << 58;
         end
      end

      // square root, two bits per step
      if (state_ff == ST_ROOT) begin
         if (sum_ff >= root_trial) begin
            sum_ff <= sum_ff - root_trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
         slot_ff <= 2'd0;
      end

      // division setup for one gain: (2|g|*2^14 + p) / (2p)
      if (state_ff == ST_DLOAD) begin
         rem_ff  <= {2'd0, gmag_ff[slot_ff], 15'd0} + 45'(p_root);
         ds_ff   <= {p_root, 15'd0};
         q_ff    <= 15'd0;
         bcnt_ff <= 4'd14;
      end

      // restoring division, one quotient bit per step
      if (state_ff == ST_DIV) begin
         if (rem_ff >= ds_ff) begin
            rem_ff <= rem_ff - ds_ff;
         end
         ds_ff   <= ds_ff >> 1;
         q_ff    <= q_next;
         bcnt_ff <= bcnt_ff - 4'd1;
         if (bcnt_ff == 4'd0) begin
            if (p_root == 30'd0) begin
               gain_ff[slot_ff] <= 16'sd0;
            end else if (gneg_ff[slot_ff]) begin
               gain_ff[slot_ff] <= $signed(16'd0 - {1'b0, q_next});
            end else begin
               gain_ff[slot_ff] <= $signed({1'b0, q_next});
            end
            slot_ff <= slot_ff + 2'd1;
            cnt_ff  <= 2'd0;
         end
      end

      // speaker id reads, then hand over to the output register
      if (state_ff == ST_SPK) begin
         if (cnt_ff != 2'd3) begin
            cnt_ff <= cnt_ff + 2'd1;
         end
         if (cnt_ff != 2'd0) begin
            if (!chosen_ff || ((cnt_ff == 2'd3) && !tri_mode)) begin
               id_ff[cnt_ff - 2'd1] <= 6'd0;
            end else begin
               id_ff[cnt_ff - 2'd1] <= spk_rd_ff;
            end
         end
         if ((cnt_ff == 2'd3) && !rsp_valid_ff) begin
            out_gain_ff[0] <= gain_ff[0];
            out_gain_ff[1] <= gain_ff[1];
            out_gain_ff[2] <= gain_ff[2];
            out_id_ff[0]   <= id_ff[0];
            out_id_ff[1]   <= id_ff[1];
            out_id_ff[2]   <= (!chosen_ff || !tri_mode) ? 6'd0 : spk_rd_ff;
            out_third_ff   <= tri_mode && chosen_ff;
         end
      end
   end

endmodule

`default_nettype wire
